/* rtl/tvs_pkg.sv */
// tvs_pkg: shared types and constants of the typed value serializer.
// No dependencies; used by the channel interfaces, tvs_shift and the top level.

package tvs_pkg;

  localparam int BufferMax = 4096;            // largest remaining-space value
  localparam int OpW       = 3;
  localparam int ValueW    = 64;
  localparam int ByteW     = 8;
  localparam int CapW      = 13;
  localparam int SpaceW    = $clog2(BufferMax + 1);
  localparam int CntW      = 4;                // holds a fixed size of up to 8
  localparam int CapMax    = (1 << CapW) - 1;
  localparam logic [CapW-1:0] CapReset =
      CapW'((BufferMax > CapMax) ? CapMax : BufferMax);

  typedef enum logic [OpW-1:0] {
    OP_FIXED1   = 3'd0,
    OP_FIXED2   = 3'd1,
    OP_FIXED4   = 3'd2,
    OP_FIXED8   = 3'd3,
    OP_VARINT   = 3'd4,
    OP_ZIGZAG32 = 3'd5,
    OP_ZIGZAG64 = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIXED,
    ST_VARINT,
    ST_ERROR
  } state_e;

  typedef struct packed {
    logic load;     // take a new value in
    logic step;     // drop the digit just sent
    logic varint;   // 7-bit digits instead of bytes
    op_e  op;       // selector of the value being loaded
  } shift_ctrl_t;

endpackage

/* rtl/tvs_in_if.sv */
// tvs_in_if: request channel carrying one typed value per request.
// Depends on tvs_pkg for field widths.

interface tvs_in_if;
  logic                         valid;
  logic                         ready;
  logic [tvs_pkg::OpW-1:0]      op;
  logic [tvs_pkg::ValueW-1:0]   value;
  logic                         start_buffer;

  modport source (output valid, op, value, start_buffer, input ready);
  modport sink   (input valid, op, value, start_buffer, output ready);
endinterface

/* rtl/tvs_out_if.sv */
// tvs_out_if: result channel, one wire byte or error indication per transfer.
// Depends on tvs_pkg for field widths.

interface tvs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tvs_pkg::ByteW-1:0]   out_byte;
  logic                        has_byte;
  logic                        status;
  logic                        last;

  modport source (output valid, out_byte, has_byte, status, last, input ready);
  modport sink   (input valid, out_byte, has_byte, status, last, output ready);
endinterface

/* rtl/tvs_shift.sv */
// tvs_shift: value shift register that hands out one byte or 7-bit group per step.
// Applies the zigzag mapping on load. Depends on tvs_pkg.

module tvs_shift (
  input  logic                        clk_i,
  input  tvs_pkg::shift_ctrl_t        ctrl_i,
  input  logic [tvs_pkg::ValueW-1:0]  value_i,
  output logic [tvs_pkg::ByteW-1:0]   digit_o,
  output logic                        rest_nz_o
);

  logic [tvs_pkg::ValueW-1:0] sh_q, sh_d;
  logic [tvs_pkg::ValueW-1:0] mapped;

  always_comb begin
    unique case (ctrl_i.op)
      tvs_pkg::OP_ZIGZAG32: begin
        mapped = {32'd0, {value_i[30:0], 1'b0} ^ {32{value_i[31]}}};
      end
      tvs_pkg::OP_ZIGZAG64: begin
        mapped = {value_i[62:0], 1'b0} ^ {64{value_i[63]}};
      end
      default: begin
        mapped = value_i;
      end
    endcase
  end

  always_comb begin
    sh_d = sh_q;
    if (ctrl_i.load) begin
      sh_d = mapped;
    end else if (ctrl_i.step) begin
      sh_d = ctrl_i.varint ? (sh_q >> 7) : (sh_q >> 8);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign digit_o   = sh_q[7:0];
  // anything left above the current 7-bit group means more bytes follow
  assign rest_nz_o = |sh_q[63:7];

endmodule

/* rtl/typed_value_serializer.sv */
// typed_value_serializer: top level of the wire-byte encoder.
// Depends on tvs_pkg, tvs_in_if, tvs_out_if and tvs_shift.

// One request carries a selector, a 64-bit value and a start_buffer flag; the
// block answers with one result per wire byte (fixed1/2/4/8 little endian, or
// varint with optional zigzag32/zigzag64 mapping) and marks the final result
// with last. A request is taken only while the block is idle; the value is
// loaded into a shift register in that cycle and then one result per cycle
// leaves it, as long as the result channel keeps taking them, so a request
// gives from 1 to 10 results (selector seven is taken and gives no result).
// The output register lets the next request be taken while the final
// result still waits on the sink. Remaining space
// is reloaded from the capacity register (saturated at 4096) when
// start_buffer is set. A fixed type short of space gives one error result
// (has_byte 0, status 1) and no bytes; a varint sends the bytes that fit and
// then an error result. Write the capacity register only while idle.

module typed_value_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tvs_in_if.sink                     in_i,
  tvs_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [tvs_pkg::CapW-1:0]   cfg_wdata_i
);

  localparam int SpaceW = tvs_pkg::SpaceW;

  tvs_pkg::state_e             state_q, state_d;
  logic [tvs_pkg::CapW-1:0]    cap_q;
  logic [SpaceW-1:0]           space_q, space_d;
  logic [tvs_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                        ovalid_q, ovalid_d;
  logic [tvs_pkg::ByteW-1:0]   byte_q, byte_d;
  logic                        has_q, has_d;
  logic                        status_q, status_d;
  logic                        last_q, last_d;

  tvs_pkg::shift_ctrl_t        shctl;
  tvs_pkg::op_e                op_in;
  logic [tvs_pkg::ByteW-1:0]   digit;
  logic                        rest_nz;
  logic                        in_acc;
  logic                        issue;
  logic [SpaceW-1:0]           reload_val;
  logic [SpaceW-1:0]           space_base;
  logic [tvs_pkg::CntW-1:0]    fsize;
  logic                        short_fixed;

  assign op_in      = tvs_pkg::op_e'(in_i.op);
  assign in_i.ready = (state_q == tvs_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  // a result can enter the output register when it is empty or being drained
  assign issue      = (state_q != tvs_pkg::ST_IDLE) && (!ovalid_q || out_o.ready);

  assign reload_val = (32'(cap_q) > tvs_pkg::BufferMax) ?
                      SpaceW'(tvs_pkg::BufferMax) : SpaceW'(cap_q);
  assign space_base = in_i.start_buffer ? reload_val : space_q;
  assign fsize      = tvs_pkg::CntW'(1) << in_i.op[1:0];
  assign short_fixed = 32'(space_base) < 32'(fsize);

  tvs_shift u_shift (
    .clk_i     (clk_i),
    .ctrl_i    (shctl),
    .value_i   (in_i.value),
    .digit_o   (digit),
    .rest_nz_o (rest_nz)
  );

  always_comb begin
    state_d      = state_q;
    space_d      = space_q;
    cnt_d        = cnt_q;
    ovalid_d     = ovalid_q && !out_o.ready;
    byte_d       = byte_q;
    has_d        = has_q;
    status_d     = status_q;
    last_d       = last_q;
    shctl.load   = 1'b0;
    shctl.step   = 1'b0;
    shctl.varint = (state_q == tvs_pkg::ST_VARINT);
    shctl.op     = op_in;

    unique case (state_q)
      tvs_pkg::ST_IDLE: begin
        if (in_acc) begin
          space_d    = space_base;
          cnt_d      = fsize;
          shctl.load = 1'b1;
          unique case (op_in)
            tvs_pkg::OP_FIXED1, tvs_pkg::OP_FIXED2,
            tvs_pkg::OP_FIXED4, tvs_pkg::OP_FIXED8: begin
              state_d = short_fixed ? tvs_pkg::ST_ERROR : tvs_pkg::ST_FIXED;
            end
            tvs_pkg::OP_VARINT, tvs_pkg::OP_ZIGZAG32,
            tvs_pkg::OP_ZIGZAG64: begin
              state_d = tvs_pkg::ST_VARINT;
            end
            default: begin
              state_d = tvs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tvs_pkg::ST_FIXED: begin
        if (issue) begin
          ovalid_d   = 1'b1;
          byte_d     = digit;
          has_d      = 1'b1;
          status_d   = 1'b0;
          last_d     = (cnt_q == tvs_pkg::CntW'(1));
          shctl.step = 1'b1;
          cnt_d      = cnt_q - tvs_pkg::CntW'(1);
          space_d    = space_q - SpaceW'(1);
          if (cnt_q == tvs_pkg::CntW'(1)) begin
            state_d = tvs_pkg::ST_IDLE;
          end
        end
      end
      tvs_pkg::ST_VARINT: begin
        if (issue) begin
          ovalid_d = 1'b1;
          if (space_q == '0) begin
            byte_d   = '0;
            has_d    = 1'b0;
            status_d = 1'b1;
            last_d   = 1'b1;
            state_d  = tvs_pkg::ST_IDLE;
          end else begin
            byte_d     = {rest_nz, digit[6:0]};
            has_d      = 1'b1;
            status_d   = 1'b0;
            last_d     = !rest_nz;
            shctl.step = 1'b1;
            space_d    = space_q - SpaceW'(1);
            if (!rest_nz) begin
              state_d = tvs_pkg::ST_IDLE;
            end
          end
        end
      end
      tvs_pkg::ST_ERROR: begin
        if (issue) begin
          ovalid_d = 1'b1;
          byte_d   = '0;
          has_d    = 1'b0;
          status_d = 1'b1;
          last_d   = 1'b1;
          state_d  = tvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tvs_pkg::ST_IDLE;
      cap_q    <= tvs_pkg::CapReset;
      space_q  <= SpaceW'(tvs_pkg::BufferMax);
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      space_q  <= space_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    has_q    <= has_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.has_byte = has_q;
  assign out_o.status   = status_q;
  assign out_o.last     = last_q;

  // an error result carries no byte and closes its request
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.has_byte) |->
      (out_o.status && out_o.last && (out_o.out_byte == '0)))
    else $error("error result with byte or without last");

  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(space_q) <= tvs_pkg::BufferMax)
    else $error("remaining space above buffer maximum");

  a_fixed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tvs_pkg::ST_FIXED && issue && cnt_q == tvs_pkg::CntW'(1)) |=>
      (state_q == tvs_pkg::ST_IDLE && out_o.last))
    else $error("fixed request did not end on its final byte");

  a_varint_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tvs_pkg::ST_VARINT && issue && space_q != '0) |=>
      (space_q == $past(space_q) - SpaceW'(1) && out_o.has_byte))
    else $error("varint byte sent without taking space");

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for typed_value_serializer (fixed, varint, zigzag wire bytes).
// Depends on tvs_pkg, tvs_in_if, tvs_out_if and the RTL top; the bench keeps its own encoder
// model and checks every result against it in order.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tvs_pkg::OpW-1:0] OpUnused = tvs_pkg::OpW'(7);  // selector that is ignored
  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 8;

  typedef struct packed {
    logic [tvs_pkg::OpW-1:0]    op;
    logic [tvs_pkg::ValueW-1:0] value;
    logic                       start_buffer;
  } value_req_t;

  typedef struct packed {
    logic [tvs_pkg::ByteW-1:0] out_byte;
    logic                      has_byte;
    logic                      status;
    logic                      last;
  } wire_result_t;

  localparam wire_result_t NoRoom = '{out_byte: '0, has_byte: 1'b0, status: 1'b1, last: 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [tvs_pkg::CapW-1:0] cfg_wdata_i;

  tvs_in_if  in_ch ();
  tvs_out_if out_ch ();

  typed_value_serializer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  // encoder model state
  logic [tvs_pkg::CapW-1:0]   capacity = tvs_pkg::CapReset;
  logic [tvs_pkg::SpaceW-1:0] space_left = tvs_pkg::SpaceW'(tvs_pkg::BufferMax);

  value_req_t   value_queue[$];
  wire_result_t wire_queue[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          pressure_armed = 1'b0;
  bit          pressure_done = 1'b0;
  int          hold_left = 0;

  // Expected wire bytes of one accepted request.
  function automatic void encode_item(input logic [tvs_pkg::OpW-1:0] op,
                                      input logic [tvs_pkg::ValueW-1:0] value,
                                      input logic reload);
    logic [tvs_pkg::ValueW-1:0] v;
    logic [31:0]                lo;
    int unsigned                size;
    bit                         done;
    if (reload)
      space_left = (capacity > tvs_pkg::BufferMax) ? tvs_pkg::SpaceW'(tvs_pkg::BufferMax)
                                                   : tvs_pkg::SpaceW'(capacity);
    unique case (op)
      tvs_pkg::OP_FIXED1, tvs_pkg::OP_FIXED2, tvs_pkg::OP_FIXED4, tvs_pkg::OP_FIXED8: begin
        size = 1 << op[1:0];
        if (space_left < size) begin
          wire_queue.push_back(NoRoom);
        end else begin
          v = value;
          for (int i = 0; i < size; i++) begin
            wire_queue.push_back('{out_byte: v[7:0], has_byte: 1'b1, status: 1'b0,
                                   last: (i == size - 1)});
            v = v >> 8;
          end
          space_left = space_left - tvs_pkg::SpaceW'(size);
        end
        return;
      end
      tvs_pkg::OP_VARINT: v = value;
      tvs_pkg::OP_ZIGZAG32: begin
        lo = value[31:0];
        v = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
      end
      tvs_pkg::OP_ZIGZAG64: v = {value[62:0], 1'b0} ^ {tvs_pkg::ValueW{value[63]}};
      default: return;
    endcase
    done = 1'b0;
    while (!done) begin
      if (space_left == 0) begin
        wire_queue.push_back(NoRoom);
        done = 1'b1;
      end else begin
        wire_queue.push_back('{out_byte: {(v >> 7) != 0, v[6:0]}, has_byte: 1'b1,
                               status: 1'b0, last: (v >> 7) == 0});
        v = v >> 7;
        space_left = space_left - tvs_pkg::SpaceW'(1);
        done = (v == 0);
      end
    end
  endfunction

  function automatic void queue_request(input logic [tvs_pkg::OpW-1:0] op,
                                        input logic [tvs_pkg::ValueW-1:0] value,
                                        input logic start_buffer);
    value_queue.push_back('{op: op, value: value, start_buffer: start_buffer});
  endfunction

  // Mixed magnitudes so every varint length shows up, plus small negatives for zigzag.
  function automatic value_req_t rand_request();
    value_req_t                 req;
    logic [tvs_pkg::ValueW-1:0] full;
    full = {$urandom, $urandom};
    req.op = tvs_pkg::OpW'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: req.value = full;
      1: req.value = full >> $urandom_range(0, 63);
      2: req.value = -(full >> $urandom_range(32, 63));
      default: req.value = tvs_pkg::ValueW'($urandom_range(0, 300));
    endcase
    req.start_buffer = ($urandom_range(0, 5) == 0);
    return req;
  endfunction

  function automatic void check_field(input string name, input logic [tvs_pkg::ByteW-1:0] want,
                                      input logic [tvs_pkg::ByteW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // Driver: offers queued requests, models each one as it is accepted.
  always @(posedge clk_i) begin : drv
    value_req_t nxt;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        encode_item(in_ch.op, in_ch.value, in_ch.start_buffer);
      if (!in_ch.valid || in_ch.ready) begin
        if (value_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = value_queue.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.op           <= nxt.op;
          in_ch.value        <= nxt.value;
          in_ch.start_buffer <= nxt.start_buffer;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure while the sender keeps offering requests.
  always @(posedge clk_i) begin : hold_ctl
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (pressure_armed && !pressure_done) begin
        hold_left     <= HoldCycles;
        pressure_done <= 1'b1;
      end
    end
  end

  // Monitor: checks accepted results in order and drives the sink's ready.
  always @(posedge clk_i) begin : mon
    wire_result_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (wire_queue.size() == 0) begin
          $error("unexpected result: out_byte %0h has_byte %0b status %0b last %0b",
                 out_ch.out_byte, out_ch.has_byte, out_ch.status, out_ch.last);
          err_count++;
        end else begin
          want = wire_queue.pop_front();
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("has_byte", tvs_pkg::ByteW'(want.has_byte),
                      tvs_pkg::ByteW'(out_ch.has_byte));
          check_field("status", tvs_pkg::ByteW'(want.status), tvs_pkg::ByteW'(out_ch.status));
          check_field("last", tvs_pkg::ByteW'(want.last), tvs_pkg::ByteW'(out_ch.last));
        end
      end
      if (hold_left != 0 || (pressure_armed && !pressure_done)) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // checked between edges so the driver and monitor updates have landed
  task automatic drain();
    while (value_queue.size() != 0 || in_ch.valid || wire_queue.size() != 0)
      @(negedge clk_i);
    // selector seven leaves no result behind, give it time to retire
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [tvs_pkg::CapW-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    capacity = cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    idle_pct  = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.op           = '0;
    in_ch.value        = '0;
    in_ch.start_buffer = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every selector and the boundary values, reset capacity
    queue_request(tvs_pkg::OP_FIXED1, '1, 1'b1);
    queue_request(tvs_pkg::OP_FIXED2, 64'h0123_4567_89ab_cdef, 1'b0);
    queue_request(tvs_pkg::OP_FIXED4, '0, 1'b0);
    queue_request(tvs_pkg::OP_FIXED8, '1, 1'b0);
    queue_request(tvs_pkg::OP_VARINT, '0, 1'b0);
    queue_request(tvs_pkg::OP_VARINT, 64'd127, 1'b0);
    queue_request(tvs_pkg::OP_VARINT, 64'd128, 1'b0);
    queue_request(tvs_pkg::OP_VARINT, '1, 1'b0);
    queue_request(tvs_pkg::OP_ZIGZAG32, 64'h0000_0000_ffff_ffff, 1'b0);
    queue_request(tvs_pkg::OP_ZIGZAG32, 64'h0000_0000_7fff_ffff, 1'b0);
    queue_request(tvs_pkg::OP_ZIGZAG32, 64'hffff_ffff_8000_0000, 1'b0);
    queue_request(tvs_pkg::OP_ZIGZAG64, 64'h8000_0000_0000_0000, 1'b0);
    queue_request(tvs_pkg::OP_ZIGZAG64, 64'h7fff_ffff_ffff_ffff, 1'b0);
    queue_request(tvs_pkg::OP_ZIGZAG64, '1, 1'b0);
    queue_request(OpUnused, '1, 1'b1);
    drain();

    // no room at all: fixed and varint both give a lone error
    write_capacity('0);
    queue_request(tvs_pkg::OP_FIXED1, 64'h5a, 1'b1);
    queue_request(tvs_pkg::OP_VARINT, '0, 1'b0);
    queue_request(OpUnused, '0, 1'b1);
    drain();

    // varint runs out mid value
    write_capacity(tvs_pkg::CapW'(3));
    queue_request(tvs_pkg::OP_FIXED4, 64'hdead_beef, 1'b1);
    queue_request(tvs_pkg::OP_VARINT, '1, 1'b0);
    queue_request(tvs_pkg::OP_FIXED1, 64'ha5, 1'b1);
    drain();

    // capacity above the maximum saturates on reload; long run of wide values
    write_capacity('1);
    set_idling(36, 36);
    queue_request(tvs_pkg::OP_FIXED8, {$urandom, $urandom}, 1'b1);
    repeat (120)
      queue_request($urandom_range(0, 1) ? tvs_pkg::OP_FIXED8 : tvs_pkg::OP_VARINT,
                    {1'b1, 31'($urandom), $urandom}, 1'b0);
    queue_request(tvs_pkg::OP_VARINT, 64'd300, 1'b1);
    drain();

    write_capacity(tvs_pkg::CapW'(10));
    set_idling(66, 0);
    repeat (50) value_queue.push_back(rand_request());
    drain();

    write_capacity(tvs_pkg::CapW'(tvs_pkg::BufferMax));
    set_idling(0, 66);
    pressure_armed = 1'b1;
    repeat (50) value_queue.push_back(rand_request());
    drain();

    write_capacity(tvs_pkg::CapW'($urandom_range(0, 200)));
    set_idling(36, 36);
    repeat (50) value_queue.push_back(rand_request());
    drain();

    write_capacity(tvs_pkg::CapW'(1));
    set_idling(0, 0);
    repeat (40) value_queue.push_back(rand_request());
    drain();

    write_capacity(tvs_pkg::CapW'($urandom_range(0, tvs_pkg::CapMax)));
    set_idling(0, 66);
    repeat (40) value_queue.push_back(rand_request());
    drain();

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tvs_pkg.sv
rtl/tvs_in_if.sv
rtl/tvs_out_if.sv
rtl/tvs_shift.sv
rtl/typed_value_serializer.sv
dv/tb_top.sv
